// ===== hdl/l1_nearest_row_search_defines.svh =====
// Assertion macros for the nearest row search block.
`ifndef L1_NEAREST_ROW_SEARCH_DEFINES_SVH
`define L1_NEAREST_ROW_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

`define L1NRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("l1nrs same-cycle check failed");

`define L1NRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("l1nrs next-cycle check failed");

`else

`define L1NRS_ASSERT_NOW(label, ante, cons)

`define L1NRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/l1nrs_pkg.sv =====
// Shared types and register codes for the nearest row search block.
package l1nrs_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 2'd1;

	localparam logic REQ_REF   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

endpackage

// ===== hdl/l1_nearest_row_search.sv =====
// Nearest reference row under L1 distance: one shared abs-diff/accumulate unit.
// A completing query holds busy after acceptance while it walks N coordinate slots and drains,
// N = rows_in_use * dims_in_use (clamped), fewer slots when an exact hit ends the walk early;
// done pulses one cycle at the end and cannot be stalled. Other items do not raise busy.
// Rate is set by the single reference memory read port feeding one abs-diff/add per cycle.
// Reset clears control, busy and the configuration registers; the memories are not cleared.
`include "l1_nearest_row_search_defines.svh"

module l1_nearest_row_search
	import l1nrs_pkg::*;
#(
	parameter int ROWS = 1024,
	parameter int DIMS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  req_type,
	input  logic [9:0]            row_index,
	input  logic [2:0]            dim_index,
	input  logic signed [31:0]    coord,
	output logic                  done,
	output logic [10:0]           match_index,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = $clog2(ROWS + 1);
	localparam int DW    = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int DCW   = $clog2(DIMS + 1);
	localparam int DEPTH = ROWS * DIMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = 32 + $clog2(DIMS);

	state_t state_q;

	logic [10:0] rows_cfg_q;
	logic [3:0]  dims_cfg_q;
	logic [CW-1:0]  nrows_c, nrows_q;
	logic [DCW-1:0] ndims_c, ndims_q;

	logic [31:0] ref_mem [DEPTH];
	logic [31:0] qry_mem [DIMS];

	logic          accept;
	logic          ref_we, qry_we, search_go;
	logic [AW-1:0] wr_addr;

	logic          issue_on, issue_done_q, found_q;
	logic [AW-1:0] addr_q;
	logic [DW-1:0] k_q;
	logic [RW-1:0] r_q;
	logic          last_dim_c, last_row_c;

	logic          v_s1, first_s1, last_s1;
	logic [RW-1:0] row_s1;
	logic [31:0]   ref_rd_s1, qry_rd_s1;

	logic          v_s2, first_s2, last_s2;
	logic [RW-1:0] row_s2;
	logic [31:0]   absd_s2;

	logic             rowdone_s3;
	logic [RW-1:0]    row_s3;
	logic [SUM_W-1:0] acc_s3;

	logic [SUM_W-1:0] best_dist_q;
	logic [RW-1:0]    best_row_q;
	logic             finish_c;
	logic             done_q;
	logic [10:0]      match_q;

	logic signed [32:0] diff_c;
	logic [32:0]        mag_c;

	// clamp the configured counts to the storage
	always_comb begin
		if (rows_cfg_q == 11'd0) begin
			nrows_c = CW'(1);
		end else if (32'(rows_cfg_q) > ROWS) begin
			nrows_c = CW'(ROWS);
		end else begin
			nrows_c = CW'(rows_cfg_q);
		end
		if (dims_cfg_q == 4'd0) begin
			ndims_c = DCW'(1);
		end else if (32'(dims_cfg_q) > DIMS) begin
			ndims_c = DCW'(DIMS);
		end else begin
			ndims_c = DCW'(dims_cfg_q);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign ref_we    = accept && (req_type == REQ_REF) &&
	                   (32'(row_index) < ROWS) && (32'(dim_index) < DIMS);
	assign qry_we    = accept && (req_type == REQ_QUERY) && (32'(dim_index) < DIMS);
	assign search_go = qry_we && (32'(dim_index) == 32'(ndims_c) - 1);
	assign wr_addr   = AW'(32'(row_index) * DIMS + 32'(dim_index));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= 11'd1;
			dims_cfg_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROWS_IN_USE: rows_cfg_q <= cfg_data[10:0];
				REG_DIMS_IN_USE: dims_cfg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// reference and query stores, read data registered
	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[wr_addr] <= coord;
		end
		ref_rd_s1 <= ref_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (qry_we) begin
			qry_mem[DW'(dim_index)] <= coord;
		end
		qry_rd_s1 <= qry_mem[k_q];
	end

	assign issue_on   = (state_q == ST_RUN) && !issue_done_q && !found_q;
	assign last_dim_c = (DCW'(k_q) == ndims_q - DCW'(1));
	assign last_row_c = (CW'(r_q) == nrows_q - CW'(1));
	assign finish_c   = (state_q == ST_RUN) && !issue_on && !v_s1 && !v_s2 && !rowdone_s3;

	// sequencer: walk row by row, one coordinate per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			issue_done_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (search_go) begin
						state_q      <= ST_RUN;
						issue_done_q <= 1'b0;
					end
				end
				ST_RUN: begin
					if (issue_on && last_dim_c && last_row_c) begin
						issue_done_q <= 1'b1;
					end
					if (finish_c) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (search_go) begin
			addr_q  <= '0;
			k_q     <= '0;
			r_q     <= '0;
			nrows_q <= nrows_c;
			ndims_q <= ndims_c;
		end else if (issue_on) begin
			if (last_dim_c) begin
				// skip the unused coordinate slots of the row
				k_q    <= '0;
				r_q    <= r_q + RW'(1);
				addr_q <= AW'(32'(addr_q) + DIMS + 1 - 32'(ndims_q));
			end else begin
				k_q    <= k_q + DW'(1);
				addr_q <= addr_q + AW'(1);
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			rowdone_s3 <= 1'b0;
		end else begin
			v_s1       <= issue_on;
			v_s2       <= v_s1;
			rowdone_s3 <= v_s2 && last_s2;
		end
	end

	assign diff_c = $signed({qry_rd_s1[31], qry_rd_s1}) - $signed({ref_rd_s1[31], ref_rd_s1});
	assign mag_c  = diff_c[32] ? 33'(-diff_c) : 33'(diff_c);

	always_ff @(posedge clk) begin
		first_s1 <= (k_q == '0);
		last_s1  <= last_dim_c;
		row_s1   <= r_q;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		absd_s2  <= mag_c[31:0];

		if (v_s2) begin
			acc_s3 <= (first_s2 ? '0 : acc_s3) + SUM_W'(absd_s2);
			row_s3 <= row_s2;
		end
	end

	// running minimum; a zero distance ends the search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (search_go) begin
			found_q <= 1'b0;
		end else if (rowdone_s3 && !found_q && (acc_s3 == '0)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (search_go) begin
			best_dist_q <= '1;
			best_row_q  <= '0;
		end else if (rowdone_s3 && !found_q) begin
			if ((acc_s3 == '0) || (acc_s3 < best_dist_q)) begin
				best_dist_q <= acc_s3;
				best_row_q  <= row_s3;
			end
		end
		if (finish_c) begin
			match_q <= 11'(32'(best_row_q) + 1);
		end
	end

	assign done        = done_q;
	assign match_index = match_q;

	`L1NRS_ASSERT_NOW(a_done_idle, done, !busy)
	`L1NRS_ASSERT_NOW(a_fall_done, $fell(busy), done)
	`L1NRS_ASSERT_NEXT(a_go_busy, search_go, busy)
	`L1NRS_ASSERT_NOW(a_found_zero, found_q && busy, best_dist_q == '0)

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the L1 nearest row search block: directed and random words.
`timescale 1ns / 100ps

module tb;
	import l1nrs_pkg::*;

	localparam int ROWS = 1024;
	localparam int DIMS = 8;
	localparam int STALL_LIMIT = 20000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [9:0]  row;
		logic [2:0]  dim;
		logic [31:0] coord;
	} search_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  req_type = REQ_REF;
	logic [9:0]            row_index = '0;
	logic [2:0]            dim_index = '0;
	logic signed [31:0]    coord = '0;
	logic                  done;
	logic [10:0]           match_index;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copies, written at the config handshake
	logic [10:0] cfg_rows = 11'd1;
	logic [3:0]  cfg_dims = 4'd1;

	// predictor state, updated when a word is taken
	logic [31:0] ref_table [0:ROWS-1][0:DIMS-1];
	logic [31:0] query_vec [0:DIMS-1];

	// generator shadow, updated when a word is queued
	logic [31:0] gen_table [0:ROWS-1][0:DIMS-1];
	bit          gen_table_ok [0:ROWS-1][0:DIMS-1];
	bit          gen_query_ok [0:DIMS-1];

	search_word_t pending_words [$];
	logic [10:0]  nearest_rows [$];
	int unsigned  words_pushed = 0;
	int unsigned  words_taken = 0;
	int unsigned  errors = 0;
	int unsigned  stall_cycles = 0;

	l1_nearest_row_search dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.row_index   (row_index),
		.dim_index   (dim_index),
		.coord       (coord),
		.done        (done),
		.match_index (match_index),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned active_rows();
		if (cfg_rows == 0) return 1;
		if (cfg_rows > ROWS) return ROWS;
		return cfg_rows;
	endfunction

	function automatic int unsigned active_dims();
		if (cfg_dims == 0) return 1;
		if (cfg_dims > DIMS) return DIMS;
		return cfg_dims;
	endfunction

	// Apply one taken word; a completing query scans the rows in use, stopping at an exact hit.
	function automatic void search_nearest(search_word_t w);
		int unsigned nr;
		int unsigned nd;
		int unsigned best_row;
		longint best_sum;
		longint row_sum;
		longint diff;
		if (w.kind == REQ_REF) begin
			ref_table[w.row][w.dim] = w.coord;
			return;
		end
		query_vec[w.dim] = w.coord;
		nd = active_dims();
		if (w.dim != nd - 1) return;
		nr = active_rows();
		best_row = 1;
		best_sum = 64'h7FFF_FFFF_FFFF_FFFF;
		for (int r = 0; r < nr; r++) begin
			row_sum = 0;
			for (int k = 0; k < nd; k++) begin
				diff = longint'($signed(query_vec[k])) - longint'($signed(ref_table[r][k]));
				row_sum += (diff < 0) ? -diff : diff;
			end
			// exact hit ends the scan
			if (row_sum == 0) begin
				best_row = r + 1;
				break;
			end
			if (row_sum < best_sum) begin
				best_sum = row_sum;
				best_row = r + 1;
			end
		end
		nearest_rows.push_back(11'(best_row));
	endfunction

	// A search must only touch table and query entries already written.
	function automatic bit search_safe(int unsigned skip_dim);
		int unsigned nr;
		int unsigned nd;
		nr = active_rows();
		nd = active_dims();
		for (int r = 0; r < nr; r++)
			for (int d = 0; d < nd; d++)
				if (!gen_table_ok[r][d]) return 1'b0;
		for (int d = 0; d < nd; d++)
			if (!gen_query_ok[d] && d != skip_dim) return 1'b0;
		return 1'b1;
	endfunction

	function automatic void push_word(logic kind, logic [9:0] row, logic [2:0] dim,
			logic [31:0] value);
		search_word_t w;
		// demote a completing query that would read unwritten entries
		if (kind == REQ_QUERY && dim == active_dims() - 1 && !search_safe(dim))
			kind = REQ_REF;
		if (kind == REQ_REF) begin
			gen_table[row][dim] = value;
			gen_table_ok[row][dim] = 1'b1;
		end else begin
			gen_query_ok[dim] = 1'b1;
		end
		w.kind = kind;
		w.row = row;
		w.dim = dim;
		w.coord = value;
		pending_words.push_back(w);
		words_pushed++;
	endfunction

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3, 4: return 32'(($urandom_range(0, 8) - 4) << 16);
			5: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	task automatic wait_idle(int unsigned settle);
		do @(posedge clk);
		while (pending_words.size() != 0 || words_pushed != words_taken || busy
			|| nearest_rows.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic config_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS_IN_USE) cfg_rows = data[10:0];
		else if (idx == REG_DIMS_IN_USE) cfg_dims = data[3:0];
	endtask

	// Reconfigure while idle, then fill every still unwritten table entry the new search reads.
	task automatic set_config(int unsigned rows_raw, int unsigned dims_raw);
		int unsigned nr;
		int unsigned nd;
		wait_idle(8);
		config_write(REG_SPARE_LO, 16'($urandom()));
		config_write(REG_ROWS_IN_USE, {5'($urandom()), 11'(rows_raw)});
		config_write(REG_DIMS_IN_USE, {12'($urandom()), 4'(dims_raw)});
		config_write(REG_SPARE_HI, 16'($urandom()));
		nr = active_rows();
		nd = active_dims();
		for (int r = 0; r < nr; r++)
			for (int d = 0; d < nd; d++)
				if (!gen_table_ok[r][d])
					push_word(REQ_REF, 10'(r), 3'(d), pick_coord());
	endtask

	task automatic run_random(int unsigned count);
		int unsigned issued;
		int unsigned nr;
		int unsigned nd;
		int unsigned pick;
		int unsigned mode;
		int unsigned src;
		int unsigned depth;
		logic [31:0] v;
		issued = 0;
		nr = active_rows();
		nd = active_dims();
		while (issued < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// full query: copy of a row, a near miss, or random
				src = $urandom_range(nr - 1);
				mode = $urandom_range(3);
				for (int k = 0; k < nd; k++) begin
					case (mode)
						0: v = gen_table[src][k];
						1: v = gen_table[src][k] + $urandom_range(0, 2) - 1;
						default: v = pick_coord();
					endcase
					push_word(REQ_QUERY, 10'($urandom()), 3'(k), v);
				end
				issued += nd;
			end else if (pick < 80) begin
				if ($urandom_range(3) == 0)
					push_word(REQ_REF, 10'($urandom()), 3'($urandom()), pick_coord());
				else
					push_word(REQ_REF, 10'($urandom_range(nr - 1)), 3'($urandom()),
						pick_coord());
				issued++;
			end else if (pick < 90) begin
				push_word(REQ_QUERY, 10'($urandom()), 3'($urandom()), pick_coord());
				issued++;
			end else begin
				// broken sequence: stop short of the last coordinate
				depth = $urandom_range(nd - 1);
				for (int k = 0; k < depth; k++)
					push_word(REQ_QUERY, 10'($urandom()), 3'(k), pick_coord());
				issued += depth;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		search_word_t got;
		search_word_t nw;
		int unsigned roll;
		int gap_left;
		int burst_left;
		bit taken;
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= REQ_REF;
			row_index <= '0;
			dim_index <= '0;
			coord <= '0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			taken = start && !busy;
			if (taken) begin
				got.kind = req_type;
				got.row = row_index;
				got.dim = dim_index;
				got.coord = coord;
				search_nearest(got);
				words_taken++;
			end
			if (!start || taken) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_words.size() != 0) begin
					nw = pending_words.pop_front();
					req_type <= nw.kind;
					row_index <= nw.row;
					dim_index <= nw.dim;
					coord <= nw.coord;
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
						gap_left = 0;
					end else begin
						roll = $urandom_range(99);
						if (roll < 3) begin
							burst_left = $urandom_range(20, 50);
							gap_left = 0;
						end else if (roll < 50) gap_left = 0;
						else if (roll < 85) gap_left = $urandom_range(1, 3);
						else if (roll < 97) gap_left = $urandom_range(4, 12);
						else gap_left = $urandom_range(20, 60);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		logic [10:0] want;
		if (arst_n && done) begin
			if (nearest_rows.size() == 0) begin
				$error("match_index: no result pending, got %0d", match_index);
				errors++;
			end else begin
				want = nearest_rows.pop_front();
				if (match_index !== want) begin
					$error("match_index: expected %0d, got %0d", want, match_index);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: one row, one coordinate; widest difference, row ignored
		push_word(REQ_REF, 10'd0, 3'd0, 32'h8000_0000);
		push_word(REQ_QUERY, 10'h3FF, 3'd0, 32'h7FFF_FFFF);
		push_word(REQ_REF, 10'h3FF, 3'd7, 32'h7FFF_FFFF);
		push_word(REQ_QUERY, 10'd0, 3'd7, 32'h0);
		push_word(REQ_QUERY, 10'h155, 3'd0, 32'h8000_0000);

		// ties go to the first row; an exact hit wins over later rows
		set_config(4, 2);
		push_word(REQ_REF, 10'd0, 3'd0, 32'h0005_0000);
		push_word(REQ_REF, 10'd0, 3'd1, 32'h0005_0000);
		push_word(REQ_REF, 10'd1, 3'd0, 32'h0001_0000);
		push_word(REQ_REF, 10'd1, 3'd1, 32'h0);
		push_word(REQ_REF, 10'd2, 3'd0, 32'h0);
		push_word(REQ_REF, 10'd2, 3'd1, 32'h0001_0000);
		push_word(REQ_REF, 10'd3, 3'd0, 32'h0001_0000);
		push_word(REQ_REF, 10'd3, 3'd1, 32'h0);
		push_word(REQ_QUERY, 10'd0, 3'd0, 32'h0);
		push_word(REQ_QUERY, 10'd0, 3'd1, 32'h0);
		push_word(REQ_QUERY, 10'd0, 3'd0, 32'h0);
		push_word(REQ_QUERY, 10'd0, 3'd1, 32'h0001_0000);
		push_word(REQ_QUERY, 10'd0, 3'd0, 32'h0001_0000);
		push_word(REQ_QUERY, 10'd0, 3'd1, 32'h0);
		push_word(REQ_QUERY, 10'd0, 3'd5, 32'h1234_5678);
		push_word(REQ_QUERY, 10'd0, 3'd1, 32'hFFFF_0000);
		run_random(60);

		set_config(1, 8);
		run_random(50);
		// zero registers clamp up to one
		set_config(0, 0);
		run_random(30);
		set_config(16, 8);
		run_random(80);
		set_config(37, 3);
		run_random(60);
		// an oversized coordinate count clamps down to the row width
		set_config(5, 15);
		run_random(40);
		set_config(48, 2);
		run_random(40);

		wait_idle(active_rows() * active_dims() + 8);
		if (errors == 0 && nearest_rows.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
